// ===== src/extent_map_request_splitter_core_assert.svh =====
// assertion macros for the extent map request splitter
`ifndef EXTENT_MAP_REQUEST_SPLITTER_CORE_ASSERT_SVH
`define EXTENT_MAP_REQUEST_SPLITTER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EMRS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define EMRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/emrs_pkg.sv =====
// shared types and constants of the extent map request splitter
package emrs_pkg;

   localparam int MAX_EXTENTS = 16;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 5;
   localparam int SECTOR_BITS = 9;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [2:0] STATUS_SEGMENT  = 3'd0;
   localparam logic [2:0] STATUS_DONE     = 3'd1;
   localparam logic [2:0] STATUS_LOAD_ACK = 3'd2;
   localparam logic [2:0] STATUS_RANGE    = 3'd3;
   localparam logic [2:0] STATUS_FAULT    = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  entry_index;
      logic [7:0]  carrier_file;
      logic [47:0] carrier_offset;
      logic [47:0] carrier_length;
      logic [51:0] logical_offset;
      logic [31:0] request_length;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  seg_file;
      logic [48:0] seg_offset;
      logic [31:0] seg_length;
      logic        is_write;
      logic [3:0]  seg_number;
      logic        last;
   } rsp_word_type;

endpackage

// ===== src/extent_map_request_splitter_core.sv =====
// extent map request splitter: extent table, range check and segment sequencer
// A word is taken when start is high and busy is low; results leave one per
// strobe and cannot be held off. Offset and length arithmetic runs through one
// 53-bit add/subtract unit stepped by a small sequencer. A load answers from
// ST_LOAD, an empty request or an unused opcode gives its result in the cycle
// after it is taken, a rejected request answers from ST_RANGE1 or ST_RANGE2.
// For a mapped request the extent scan walks the table once per request, one
// entry per cycle, and each segment then needs five steps of the shared unit
// (offset within, room left, take, carrier offset, advance). Busy stays high
// until the last result of the word is out.
`include "extent_map_request_splitter_core_assert.svh"

module extent_map_request_splitter_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  emrs_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output emrs_pkg::rsp_word_type rsp_word
);
   import emrs_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_LOAD    = 10'b00_0000_0010,
      ST_RANGE1  = 10'b00_0000_0100,
      ST_RANGE2  = 10'b00_0000_1000,
      ST_SCAN    = 10'b00_0001_0000,
      ST_WITHIN  = 10'b00_0010_0000,
      ST_AVAIL   = 10'b00_0100_0000,
      ST_TAKE    = 10'b00_1000_0000,
      ST_EMIT    = 10'b01_0000_0000,
      ST_ADVANCE = 10'b10_0000_0000
   } state_type;

   state_type    state_ff, state_in;
   req_word_type req_ff, req_in;
   logic [CNT_W-1:0] entries_loaded_ff, entries_loaded_in;
   logic [52:0]  total_ff, total_in;
   logic [51:0]  cur_ff, cur_in;
   logic [31:0]  rem_ff, rem_in;
   logic [52:0]  acc_ff, acc_in;
   logic [51:0]  within_ff, within_in;
   logic [31:0]  take_ff, take_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic         found_ff, found_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic         rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic [7:0]   ext_file [MAX_EXTENTS];
   logic [47:0]  ext_carrier_start [MAX_EXTENTS];
   logic [47:0]  ext_aligned_length [MAX_EXTENTS];
   logic [51:0]  ext_logical_start [MAX_EXTENTS];

   logic [IDX_W-1:0] rd_idx;
   logic         ext_we;
   logic [47:0]  aligned;
   logic         wr;
   logic [52:0]  alu_a, alu_b;
   logic         alu_sub;
   logic [53:0]  alu_sum;
   logic         alu_borrow;

   assign rd_idx  = (state_ff == ST_SCAN) ? scan_ff[IDX_W-1:0] : pick_ff;
   assign aligned = {req_ff.carrier_length[47:SECTOR_BITS], {SECTOR_BITS{1'b0}}};
   assign wr      = (req_ff.op == OP_WRITE);

   // shared add/subtract unit
   assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 54'(alu_sub);
   assign alu_borrow = alu_sub & ~alu_sum[53];

   always_comb begin
      state_in          = state_ff;
      req_in            = req_ff;
      entries_loaded_in = entries_loaded_ff;
      total_in          = total_ff;
      cur_in            = cur_ff;
      rem_in            = rem_ff;
      acc_in            = acc_ff;
      within_in         = within_ff;
      take_in           = take_ff;
      scan_in           = scan_ff;
      pick_in           = pick_ff;
      found_in          = found_ff;
      count_in          = count_ff;
      rsp_strobe_in     = 1'b0;
      rsp_word_in       = '0;
      ext_we            = 1'b0;
      alu_a             = '0;
      alu_b             = '0;
      alu_sub           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_word;
               cur_in = req_word.logical_offset;
               rem_in = req_word.request_length;
               unique case (req_word.op) inside
                  OP_LOAD: begin
                     if (req_word.entry_index != '0 &&
                         {1'b0, req_word.entry_index} != entries_loaded_ff) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_word_in.status = STATUS_RANGE;
                        rsp_word_in.last   = 1'b1;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  OP_READ, OP_WRITE: begin
                     if (req_word.request_length == '0) begin
                        rsp_strobe_in        = 1'b1;
                        rsp_word_in.status   = STATUS_DONE;
                        rsp_word_in.is_write = (req_word.op == OP_WRITE);
                        rsp_word_in.last     = 1'b1;
                     end else begin
                        state_in = ST_RANGE1;
                     end
                  end
                  default: begin
                     rsp_strobe_in      = 1'b1;
                     rsp_word_in.status = STATUS_RANGE;
                     rsp_word_in.last   = 1'b1;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            alu_a             = (req_ff.entry_index == '0) ? '0 : total_ff;
            alu_b             = {5'b0, aligned};
            ext_we            = 1'b1;
            total_in          = alu_sum[52:0];
            entries_loaded_in = CNT_W'({1'b0, req_ff.entry_index} + 5'd1);
            rsp_strobe_in      = 1'b1;
            rsp_word_in.status = STATUS_LOAD_ACK;
            rsp_word_in.last   = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_RANGE1: begin
            alu_a   = total_ff;
            alu_b   = {1'b0, cur_ff};
            alu_sub = 1'b1;
            acc_in  = alu_sum[52:0];
            if (alu_borrow) begin
               rsp_strobe_in        = 1'b1;
               rsp_word_in.status   = STATUS_RANGE;
               rsp_word_in.is_write = wr;
               rsp_word_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_RANGE2;
            end
         end
         ST_RANGE2: begin
            alu_a   = acc_ff;
            alu_b   = {21'b0, rem_ff};
            alu_sub = 1'b1;
            if (alu_borrow) begin
               rsp_strobe_in        = 1'b1;
               rsp_word_in.status   = STATUS_RANGE;
               rsp_word_in.is_write = wr;
               rsp_word_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               scan_in  = '0;
               pick_in  = '0;
               found_in = 1'b0;
               count_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // last loaded extent that starts at or below the current offset
            alu_a   = {1'b0, cur_ff};
            alu_b   = {1'b0, ext_logical_start[rd_idx]};
            alu_sub = 1'b1;
            if (scan_ff < entries_loaded_ff && !alu_borrow) begin
               pick_in  = scan_ff[IDX_W-1:0];
               found_in = 1'b1;
               scan_in  = scan_ff + 5'd1;
            end else begin
               state_in = ST_WITHIN;
            end
         end
         ST_WITHIN: begin
            alu_a     = {1'b0, cur_ff};
            alu_b     = {1'b0, ext_logical_start[rd_idx]};
            alu_sub   = 1'b1;
            within_in = alu_sum[51:0];
            if (!found_ff || count_ff[CNT_W-1]) begin
               rsp_strobe_in        = 1'b1;
               rsp_word_in.status   = STATUS_FAULT;
               rsp_word_in.is_write = wr;
               rsp_word_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_AVAIL;
            end
         end
         ST_AVAIL: begin
            alu_a   = {5'b0, ext_aligned_length[rd_idx]};
            alu_b   = {1'b0, within_ff};
            alu_sub = 1'b1;
            acc_in  = alu_sum[52:0];
            if (alu_borrow || alu_sum[52:0] == '0) begin
               rsp_strobe_in        = 1'b1;
               rsp_word_in.status   = STATUS_FAULT;
               rsp_word_in.is_write = wr;
               rsp_word_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            alu_a   = {21'b0, rem_ff};
            alu_b   = acc_ff;
            alu_sub = 1'b1;
            if (alu_borrow) begin
               take_in = rem_ff;
               rem_in  = '0;
            end else begin
               take_in = acc_ff[31:0];
               rem_in  = alu_sum[31:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            alu_a = {5'b0, ext_carrier_start[rd_idx]};
            alu_b = {1'b0, within_ff};
            rsp_strobe_in          = 1'b1;
            rsp_word_in.status     = STATUS_SEGMENT;
            rsp_word_in.seg_file   = ext_file[rd_idx];
            rsp_word_in.seg_offset = alu_sum[48:0];
            rsp_word_in.seg_length = take_ff;
            rsp_word_in.is_write   = wr;
            rsp_word_in.seg_number = count_ff[IDX_W-1:0];
            rsp_word_in.last       = (rem_ff == '0);
            count_in               = count_ff + 5'd1;
            state_in               = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            alu_a    = {1'b0, cur_ff};
            alu_b    = {21'b0, take_ff};
            cur_in   = alu_sum[51:0];
            state_in = (rem_ff == '0) ? ST_IDLE : ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         entries_loaded_ff <= '0;
         total_ff          <= '0;
         rsp_strobe_ff     <= 1'b0;
         found_ff          <= 1'b0;
         count_ff          <= '0;
         scan_ff           <= '0;
         pick_ff           <= '0;
      end else begin
         state_ff          <= state_in;
         entries_loaded_ff <= entries_loaded_in;
         total_ff          <= total_in;
         rsp_strobe_ff     <= rsp_strobe_in;
         found_ff          <= found_in;
         count_ff          <= count_in;
         scan_ff           <= scan_in;
         pick_ff           <= pick_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      within_ff   <= within_in;
      take_ff     <= take_in;
      rsp_word_ff <= rsp_word_in;
   end

   // extent table
   always_ff @(posedge clock) begin
      if (ext_we) begin
         ext_file[req_ff.entry_index]           <= req_ff.carrier_file;
         ext_carrier_start[req_ff.entry_index]  <= req_ff.carrier_offset;
         ext_aligned_length[req_ff.entry_index] <= aligned;
         ext_logical_start[req_ff.entry_index]  <= alu_a[51:0];
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   `EMRS_ASSERT_NEXT(a_more_follows, rsp_strobe && !rsp_word.last, busy, "word ended early")
   `EMRS_ASSERT_NOW(a_single_last, rsp_strobe && rsp_word.status != STATUS_SEGMENT, rsp_word.last, "non-segment result not last")
   `EMRS_ASSERT_NOW(a_seg_nonempty, rsp_strobe && rsp_word.status == STATUS_SEGMENT, rsp_word.seg_length != '0, "empty segment")
   `EMRS_ASSERT_NOW(a_ack_loaded, rsp_strobe && rsp_word.status == STATUS_LOAD_ACK, entries_loaded_ff != '0 && entries_loaded_ff <= CNT_W'(MAX_EXTENTS), "load ack with bad table count")

endmodule
